[rtl/lpht_pkg.sv]
package lpht_pkg;

   localparam int TableSlots = 1024;
   localparam int SlotBits = $clog2(TableSlots);
   localparam int CountBits = $clog2(TableSlots + 1);
   localparam int QueueDepth = 2;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [1:0] FUNC_ERASE = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;
   localparam logic [1:0] STATUS_RESERVED = 2'd3;

   localparam logic [63:0] TombAddr = '1;
   localparam logic [63:0] MixMulA = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MixMulB = 64'h94d049bb133111eb;

   typedef struct packed {
      logic [1:0] func;
      logic [63:0] key;
      logic [63:0] value_addr;
      logic [30:0] value_thread;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [63:0] found_addr;
      logic [30:0] found_thread;
   } rsp_type;

   // Work handed from the front end to the probe engine.
   typedef struct packed {
      logic direct;
      logic [1:0] direct_status;
      logic [SlotBits-1:0] start;
      req_type req;
   } job_type;

endpackage

[rtl/lpht_ram.sv]
module lpht_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] wr_addr,
   input logic [Width-1:0] wr_data,
   input logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lpht_mul.sv]
module lpht_mul (
   input logic clock,
   input logic [63:0] a,
   input logic [63:0] b,
   output logic [63:0] p
);

   // The low 64 bits of a product, taken from three 32 by 32 partial products.
   logic [63:0] ll_ff;
   logic [31:0] lh_ff;
   logic [31:0] hl_ff;
   logic [63:0] ll_in;
   logic [63:0] lh_in;
   logic [63:0] hl_in;

   assign ll_in = a[31:0] * b[31:0];
   assign lh_in = a[31:0] * b[63:32];
   assign hl_in = a[63:32] * b[31:0];

   always_ff @(posedge clock) begin
      ll_ff <= ll_in;
      lh_ff <= lh_in[31:0];
      hl_ff <= hl_in[31:0];
   end

   assign p = ll_ff + {lh_ff + hl_ff, 32'd0};

endmodule

[rtl/lpht_front.sv]
module lpht_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input lpht_pkg::req_type req_data,
   output logic job_valid,
   input logic job_stall,
   output lpht_pkg::job_type job_data
);
   import lpht_pkg::*;

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StMulA = 3'd1;
   localparam logic [2:0] StMulB = 3'd2;
   localparam logic [2:0] StPush = 3'd3;
   localparam logic [2:0] StWaitA = 3'd4;
   localparam logic [2:0] StWaitB = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   req_type req_ff;
   logic [63:0] x_ff;
   logic [63:0] x_in;
   logic [63:0] mul_a;
   logic [63:0] mul_b;
   logic [63:0] mul_p;
   logic [63:0] mixed;

   lpht_mul u_mul (
      .clock(clock),
      .a(mul_a),
      .b(mul_b),
      .p(mul_p)
   );

   assign mul_a = x_ff;
   assign mul_b = (state_ff == StMulA) ? MixMulA : MixMulB;
   assign mixed = mul_p ^ (mul_p >> 31);

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               x_in = req_data.key ^ (req_data.key >> 30);
               state_in = StMulA;
            end
         end
         StMulA: state_in = StWaitA;
         StWaitA: begin
            x_in = mul_p ^ (mul_p >> 27);
            state_in = StMulB;
         end
         StMulB: state_in = StWaitB;
         StWaitB: begin
            x_in = mixed;
            state_in = StPush;
         end
         StPush: begin
            if (!job_stall) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
      x_ff <= x_in;
      if (state_ff == StIdle && req_valid) begin
         req_ff <= req_data;
      end
   end

   assign req_stall = (state_ff != StIdle);
   assign job_valid = (state_ff == StPush);

   always_comb begin
      job_data.req = req_ff;
      job_data.start = x_ff[SlotBits-1:0];
      job_data.direct = 1'b1;
      job_data.direct_status = STATUS_MISS;
      if (req_ff.func != FUNC_INSERT && req_ff.func != FUNC_LOOKUP
            && req_ff.func != FUNC_ERASE) begin
         job_data.direct_status = STATUS_MISS;
      end else if (req_ff.key == '0) begin
         job_data.direct_status = STATUS_RESERVED;
      end else begin
         job_data.direct = 1'b0;
      end
   end

endmodule

[rtl/lpht_queue.sv]
module lpht_queue (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_stall,
   input lpht_pkg::job_type in_data,
   output logic out_valid,
   input logic out_stall,
   output lpht_pkg::job_type out_data
);
   import lpht_pkg::*;

   localparam int PtrBits = $clog2(QueueDepth);

   job_type entry_ff [QueueDepth];
   logic [PtrBits-1:0] wr_ff;
   logic [PtrBits-1:0] rd_ff;
   logic [PtrBits:0] count_ff;
   logic push;
   logic pop;

   assign in_stall = (count_ff == (PtrBits + 1)'(QueueDepth));
   assign out_valid = (count_ff != '0);
   assign out_data = entry_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PtrBits'(QueueDepth - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PtrBits'(QueueDepth - 1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + (PtrBits + 1)'(push) - (PtrBits + 1)'(pop);
      end
      if (push) begin
         entry_ff[wr_ff] <= in_data;
      end
   end

endmodule

[rtl/lpht_back.sv]
module lpht_back (
   input logic clock,
   input logic reset,
   input logic job_valid,
   output logic job_stall,
   input lpht_pkg::job_type job_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output lpht_pkg::rsp_type rsp_data
);
   import lpht_pkg::*;

   localparam logic [2:0] StClear = 3'd0;
   localparam logic [2:0] StIdle = 3'd1;
   localparam logic [2:0] StRead = 3'd2;
   localparam logic [2:0] StCheck = 3'd3;
   localparam logic [2:0] StValue = 3'd4;
   localparam logic [2:0] StDone = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   job_type job_ff;
   logic [SlotBits-1:0] pos_ff;
   logic [SlotBits-1:0] pos_in;
   logic [CountBits-1:0] seen_ff;
   logic [CountBits-1:0] seen_in;
   logic hit_ff;
   logic hit_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   logic key_we;
   logic [SlotBits-1:0] key_wa;
   logic [63:0] key_wd;
   logic [SlotBits-1:0] rd_addr;
   logic [63:0] key_rd;
   logic val_we;
   logic [94:0] val_wd;
   logic [94:0] val_rd;

   lpht_ram #(.Width(64), .Depth(TableSlots)) u_keys (
      .clock(clock),
      .wr_en(key_we),
      .wr_addr(key_wa),
      .wr_data(key_wd),
      .rd_addr(rd_addr),
      .rd_data(key_rd)
   );

   lpht_ram #(.Width(95), .Depth(TableSlots)) u_values (
      .clock(clock),
      .wr_en(val_we),
      .wr_addr(key_wa),
      .wr_data(val_wd),
      .rd_addr(rd_addr),
      .rd_data(val_rd)
   );

   assign job_stall = (state_ff != StIdle);
   assign rd_addr = pos_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      seen_in = seen_ff;
      hit_in = hit_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      key_we = 1'b0;
      key_wa = pos_ff;
      key_wd = job_ff.req.key;
      val_we = 1'b0;
      val_wd = {job_ff.req.value_addr, job_ff.req.value_thread};
      unique case (state_ff)
         StClear: begin
            key_we = 1'b1;
            key_wd = '0;
            val_we = 1'b1;
            val_wd = '0;
            pos_in = pos_ff + 1'b1;
            if (pos_ff == SlotBits'(TableSlots - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (job_valid) begin
               pos_in = job_data.start;
               seen_in = '0;
               state_in = job_data.direct ? StDone : StRead;
            end
         end
         StRead: state_in = StCheck;
         StCheck: begin
            if (key_rd == '0 || key_rd == job_ff.req.key) begin
               hit_in = (key_rd != '0);
               state_in = StValue;
            end else if (seen_ff == CountBits'(TableSlots - 1)) begin
               state_in = StDone;
               seen_in = CountBits'(TableSlots);
            end else begin
               seen_in = seen_ff + 1'b1;
               pos_in = (pos_ff == SlotBits'(TableSlots - 1)) ? '0 : pos_ff + 1'b1;
               state_in = StRead;
            end
         end
         StValue: begin
            if (job_ff.req.func == FUNC_INSERT) begin
               key_we = 1'b1;
               val_we = 1'b1;
            end else if (job_ff.req.func == FUNC_ERASE && hit_ff) begin
               val_we = 1'b1;
               val_wd = {TombAddr, 31'd0};
            end
            state_in = StDone;
         end
         StDone: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.found_addr = '0;
               rsp_in.found_thread = '0;
               if (job_ff.direct) begin
                  rsp_in.status = job_ff.direct_status;
               end else if (seen_ff == CountBits'(TableSlots)) begin
                  rsp_in.status = STATUS_FULL;
               end else if (job_ff.req.func == FUNC_INSERT) begin
                  rsp_in.status = STATUS_OK;
               end else if (job_ff.req.func == FUNC_ERASE) begin
                  rsp_in.status = hit_ff ? STATUS_OK : STATUS_MISS;
               end else if (hit_ff && val_rd[94:31] != TombAddr) begin
                  rsp_in.status = STATUS_OK;
                  rsp_in.found_addr = val_rd[94:31];
                  rsp_in.found_thread = val_rd[30:0];
               end else begin
                  rsp_in.status = STATUS_MISS;
               end
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear;
         pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seen_ff <= seen_in;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
      if (state_ff == StIdle && job_valid) begin
         job_ff <= job_data;
      end
   end

endmodule

[rtl/linear_probe_hash_table_core.sv]
// Key/value table with open addressing and linear probing.
// Each word on the req_ channel carries func, key and the value to insert;
// exactly one rsp_ word follows for each, in order, with status and the
// value found by a lookup.
// A word is taken at a rising edge with its valid high and its stall low.
// The front end hashes the key with the splitmix64 finalizer on one
// shared multiplier of three 32 by 32 partial products, then hands the
// job to a two-entry queue. The back end walks the slots; for each it
// reads the slot memories through their registered read (StRead, then
// StCheck), and it ends with StValue and StDone to finish and answer.
// Hashing of the next request overlaps the walk of the previous one.
// A full table is walked through all 1024 slots before STATUS_FULL.
// After reset the back end clears all 1024 slots, one per cycle; requests
// are hashed and queued meanwhile but wait for the clear to finish.
// A stalled response holds its word; the back end then waits, the queue
// fills and the req_ channel stalls.
module linear_probe_hash_table_core (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input lpht_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output lpht_pkg::rsp_type rsp_data
);
   import lpht_pkg::*;

   logic fq_valid;
   logic fq_stall;
   job_type fq_data;
   logic qb_valid;
   logic qb_stall;
   job_type qb_data;

   lpht_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .job_valid(fq_valid),
      .job_stall(fq_stall),
      .job_data(fq_data)
   );

   lpht_queue u_queue (
      .clock(clock),
      .reset(reset),
      .in_valid(fq_valid),
      .in_stall(fq_stall),
      .in_data(fq_data),
      .out_valid(qb_valid),
      .out_stall(qb_stall),
      .out_data(qb_data)
   );

   lpht_back u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(qb_valid),
      .job_stall(qb_stall),
      .job_data(qb_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule
